// ===== src/pmsm_pkg.sv =====
package pmsm_pkg;

    localparam int FRAC_BITS   = 32;
    localparam int STATE_WIDTH = 48;
    localparam int VAL_W       = 64;
    localparam int CFG_W       = 48;
    localparam int CFG_IDX_W   = 3;
    localparam int REG_W       = 6;
    localparam int IDX_W       = 6;

    // Steps of one derivative evaluation, and the last step of each stage.
    localparam logic [IDX_W-1:0] DERIV_LEN = 6'd23;
    localparam logic [IDX_W-1:0] LAST_MID  = 6'd34;
    localparam logic [IDX_W-1:0] LAST_FIN  = 6'd54;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RES, CFG_IND, CFG_LAM, CFG_POLES, CFG_TSF, CFG_MU, CFG_TL, CFG_JL
    } t_cfg_idx;

    typedef struct packed {
        logic [63:0]                   sim_time;
        logic signed [CFG_W-1:0]       volt_d;
        logic signed [CFG_W-1:0]       volt_q;
    } t_in_item;

    typedef struct packed {
        logic signed [STATE_WIDTH-1:0] current_d;
        logic signed [STATE_WIDTH-1:0] current_q;
        logic signed [STATE_WIDTH-1:0] rotor_angle;
        logic signed [STATE_WIDTH-1:0] rotor_speed;
    } t_out_item;

    typedef enum logic [2:0] {
        OP_NOP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SAT, OP_WRAP, OP_DIV6
    } t_op;

    // Operand and destination names of the shared unit.
    typedef enum logic [REG_W-1:0] {
        R_X0, R_X1, R_X2, R_X3,
        R_S0, R_S1, R_S2, R_S3,
        R_K0, R_K1, R_K2, R_K3,
        R_A0, R_A1, R_A2, R_A3,
        R_B0, R_B1, R_B2, R_B3,
        R_C0, R_C1, R_C2, R_C3,
        R_T0, R_T1, R_T2, R_DT, R_H, R_VD, R_VQ,
        R_ZERO, R_C15, R_NP, R_RES, R_IND, R_LAM, R_TSF, R_MU, R_TL, R_JL
    } t_reg;

    typedef struct packed {
        t_op  op;
        t_reg dst;
        t_reg a;
        t_reg b;
    } t_uop;

    function automatic t_reg reg_at(t_reg base, logic [1:0] i);
        return t_reg'(REG_W'(base) + REG_W'(i));
    endfunction

    function automatic t_uop uop(t_op op, t_reg dst, t_reg a, t_reg b);
        t_uop u;
        u.op  = op;
        u.dst = dst;
        u.a   = a;
        u.b   = b;
        return u;
    endfunction

    // Microprogram: a derivative evaluation, then the stage's bookkeeping.
    function automatic t_uop ucode(logic [1:0] stage, logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] j;
        logic [2:0]       m;
        logic [1:0]       i;
        t_uop             u;
        u = uop(OP_NOP, R_ZERO, R_ZERO, R_ZERO);
        j = idx - DERIV_LEN;
        m = 3'(j - 6'd4);
        i = 2'b00;
        if (idx < DERIV_LEN) begin
            case (idx)
                6'd0:  u = uop(OP_MUL, R_T0, R_C15, R_NP);
                6'd1:  u = uop(OP_MUL, R_T0, R_T0, R_LAM);
                6'd2:  u = uop(OP_MUL, R_T0, R_T0, R_S1);
                6'd3:  u = uop(OP_MUL, R_T1, R_RES, R_S0);
                6'd4:  u = uop(OP_SUB, R_T1, R_VD, R_T1);
                6'd5:  u = uop(OP_DIV, R_T1, R_T1, R_IND);
                6'd6:  u = uop(OP_MUL, R_T2, R_NP, R_S3);
                6'd7:  u = uop(OP_MUL, R_T2, R_T2, R_S1);
                6'd8:  u = uop(OP_ADD, R_K0, R_T1, R_T2);
                6'd9:  u = uop(OP_DIV, R_T1, R_LAM, R_IND);
                6'd10: u = uop(OP_ADD, R_T1, R_T1, R_S0);
                6'd11: u = uop(OP_MUL, R_T1, R_T1, R_NP);
                6'd12: u = uop(OP_MUL, R_T1, R_T1, R_S3);
                6'd13: u = uop(OP_MUL, R_T2, R_RES, R_S1);
                6'd14: u = uop(OP_SUB, R_T2, R_VQ, R_T2);
                6'd15: u = uop(OP_DIV, R_T2, R_T2, R_IND);
                6'd16: u = uop(OP_SUB, R_K1, R_T2, R_T1);
                6'd17: u = uop(OP_ADD, R_K2, R_S3, R_ZERO);
                6'd18: u = uop(OP_SUB, R_T0, R_T0, R_TSF);
                6'd19: u = uop(OP_MUL, R_T1, R_MU, R_S3);
                6'd20: u = uop(OP_SUB, R_T0, R_T0, R_T1);
                6'd21: u = uop(OP_SUB, R_T0, R_T0, R_TL);
                6'd22: u = uop(OP_DIV, R_K3, R_T0, R_JL);
                default: u = uop(OP_NOP, R_ZERO, R_ZERO, R_ZERO);
            endcase
        end else if (stage != 2'd3) begin
            if (j < 6'd4) begin
                i = j[1:0];
                case (stage)
                    2'd0:    u = uop(OP_ADD, reg_at(R_A0, i), reg_at(R_K0, i), R_ZERO);
                    2'd1:    u = uop(OP_ADD, reg_at(R_B0, i), reg_at(R_K0, i), reg_at(R_K0, i));
                    default: u = uop(OP_ADD, reg_at(R_C0, i), reg_at(R_K0, i), reg_at(R_K0, i));
                endcase
            end else begin
                i = m[2:1];
                if (!m[0]) begin
                    u = uop(OP_MUL, R_T0, reg_at(R_K0, i), (stage == 2'd2) ? R_DT : R_H);
                end else begin
                    u = uop(OP_ADD, reg_at(R_S0, i), reg_at(R_X0, i), R_T0);
                end
            end
        end else begin
            i = j[4:3];
            case (j[2:0])
                3'd0: u = uop(OP_ADD, R_T0, reg_at(R_A0, i), reg_at(R_K0, i));
                3'd1: u = uop(OP_ADD, R_T0, R_T0, reg_at(R_B0, i));
                3'd2: u = uop(OP_ADD, R_T0, R_T0, reg_at(R_C0, i));
                3'd3: u = uop(OP_MUL, R_T0, R_T0, R_DT);
                3'd4: u = uop(OP_DIV6, R_T0, R_T0, R_ZERO);
                3'd5: u = uop((i == 2'd2) ? OP_WRAP : OP_SAT, reg_at(R_X0, i),
                              reg_at(R_X0, i), R_T0);
                default: u = uop(OP_NOP, R_ZERO, R_ZERO, R_ZERO);
            endcase
        end
        return u;
    endfunction

endpackage

// ===== src/pmsm_dq_rk4_step_top.sv =====
// Motor emulator for a permanent-magnet synchronous machine in the dq frame. Each input
// transfer carries an absolute time and the d and q voltages; the block advances the
// d and q currents, rotor angle and speed by one fourth-order Runge-Kutta step of length
// (time - previous time) and answers with one output transfer holding the four state
// values. A time of zero skips the integration and returns the state unchanged. Otherwise
// all arithmetic runs on one shared unit under a microprogram of 160 steps, with sixteen
// divisions on a one-bit-per-cycle restoring divider; the multiplies, and the final
// divisions by six done as a reciprocal multiply, take four 32x32 partial products each.
// The block takes a new item only while idle, but a finished result may wait in the
// output register meanwhile. Configuration registers are written through a simple write
// port; the user must write them only while idle, as the block itself does not enforce it.
module pmsm_dq_rk4_step_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  pmsm_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output pmsm_pkg::t_out_item            o_out_data,
    input  logic                           i_cfg_we,
    input  logic [pmsm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pmsm_pkg::CFG_W-1:0]     i_cfg_data
);
    import pmsm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ISSUE, ST_MUL, ST_DIV, ST_FIN, ST_DONE
    } t_state;

    localparam logic [46:0] ONE_CFG = 47'(1) << FRAC_BITS;
    localparam logic [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic [63:0] S64_MIN = {1'b1, {63{1'b0}}};
    localparam logic [64:0] ST_MAX  = 65'((65'(1) << (STATE_WIDTH - 1)) - 65'(1));
    localparam logic [64:0] ST_MIN  = ~ST_MAX;
    // Reciprocal of three scaled by 2^65; m/6 is (m/2)/3, taken as the top product bits.
    localparam logic [63:0] RECIP3  = 64'hAAAA_AAAA_AAAA_AAAB;

    // Configuration
    logic [46:0] r_res, r_ind, r_lam, r_mu, r_jl;
    logic [6:0]  r_poles;
    logic [47:0] r_tsf, r_tl;

    // Working registers
    logic [63:0] r_x [4];
    logic [63:0] r_s [4];
    logic [63:0] r_k [4];
    logic [63:0] r_ka [4];
    logic [63:0] r_kb [4];
    logic [63:0] r_kc [4];
    logic [63:0] r_t0, r_t1, r_t2, r_dt, r_h, r_vd, r_vq;
    logic [63:0] r_prev;

    // Shared unit
    logic [127:0] r_acc;
    logic [63:0]  r_ma, r_mb, r_rem, r_den;
    logic         r_neg;
    logic [6:0]   r_cnt;

    // Sequencer
    t_state           r_state;
    logic [1:0]       r_stage;
    logic [IDX_W-1:0] r_idx;
    logic             r_out_valid;
    t_out_item        r_out;

    t_uop         w_uop;
    logic [63:0]  w_opa, w_opb, w_alu, w_val, w_dt, w_hsum;
    logic [64:0]  w_sum, w_dif, w_rem2;
    logic [63:0]  w_prod;
    logic [127:0] w_part, w_fmag;
    logic         w_ge, w_wen, w_adv, w_last, w_fire, w_simple;

    function automatic logic [63:0] mag(logic [63:0] v);
        return v[63] ? 64'(-v) : v;
    endfunction

    function automatic logic [63:0] sat64(logic [64:0] v);
        if (v[64] != v[63]) begin
            return v[64] ? S64_MIN : S64_MAX;
        end
        return v[63:0];
    endfunction

    function automatic logic [63:0] from_mag(logic neg, logic [127:0] m);
        logic [63:0] lo;
        lo = m[63:0];
        if (|m[127:64]) begin
            return neg ? S64_MIN : S64_MAX;
        end
        if (neg) begin
            if (lo > S64_MIN) begin
                return S64_MIN;
            end
            return 64'(-lo);
        end
        if (lo[63]) begin
            return S64_MAX;
        end
        return lo;
    endfunction

    function automatic logic [63:0] rd(t_reg s);
        unique case (s)
            R_X0:   return r_x[0];
            R_X1:   return r_x[1];
            R_X2:   return r_x[2];
            R_X3:   return r_x[3];
            R_S0:   return r_s[0];
            R_S1:   return r_s[1];
            R_S2:   return r_s[2];
            R_S3:   return r_s[3];
            R_K0:   return r_k[0];
            R_K1:   return r_k[1];
            R_K2:   return r_k[2];
            R_K3:   return r_k[3];
            R_A0:   return r_ka[0];
            R_A1:   return r_ka[1];
            R_A2:   return r_ka[2];
            R_A3:   return r_ka[3];
            R_B0:   return r_kb[0];
            R_B1:   return r_kb[1];
            R_B2:   return r_kb[2];
            R_B3:   return r_kb[3];
            R_C0:   return r_kc[0];
            R_C1:   return r_kc[1];
            R_C2:   return r_kc[2];
            R_C3:   return r_kc[3];
            R_T0:   return r_t0;
            R_T1:   return r_t1;
            R_T2:   return r_t2;
            R_DT:   return r_dt;
            R_H:    return r_h;
            R_VD:   return r_vd;
            R_VQ:   return r_vq;
            R_C15:  return 64'(3) << (FRAC_BITS - 1);
            R_NP:   return 64'(r_poles) << FRAC_BITS;
            R_RES:  return 64'(r_res);
            R_IND:  return 64'(r_ind);
            R_LAM:  return 64'(r_lam);
            R_TSF:  return {{16{r_tsf[47]}}, r_tsf};
            R_MU:   return 64'(r_mu);
            R_TL:   return {{16{r_tl[47]}}, r_tl};
            R_JL:   return 64'(r_jl);
            default: return 64'd0;
        endcase
    endfunction

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_fire      = i_in_valid && o_in_ready;

    always_comb begin
        w_uop    = ucode(r_stage, r_idx);
        w_opa    = rd(w_uop.a);
        w_opb    = rd(w_uop.b);
        w_sum    = {w_opa[63], w_opa} + {w_opb[63], w_opb};
        w_dif    = {w_opa[63], w_opa} - {w_opb[63], w_opb};
        w_simple = (w_uop.op != OP_MUL) && (w_uop.op != OP_DIV) && (w_uop.op != OP_DIV6);
        case (w_uop.op)
            OP_SUB:  w_alu = sat64(w_dif);
            OP_WRAP: w_alu = {{(64 - STATE_WIDTH){w_sum[STATE_WIDTH-1]}},
                              w_sum[STATE_WIDTH-1:0]};
            OP_SAT: begin
                if ($signed(w_sum) > $signed(ST_MAX)) begin
                    w_alu = ST_MAX[63:0];
                end else if ($signed(w_sum) < $signed(ST_MIN)) begin
                    w_alu = ST_MIN[63:0];
                end else begin
                    w_alu = w_sum[63:0];
                end
            end
            default: w_alu = sat64(w_sum);
        endcase

        // One 32x32 partial product per cycle, placed by its digit weights.
        w_prod = r_ma[32*r_cnt[1] +: 32] * r_mb[32*r_cnt[0] +: 32];
        case (2'(r_cnt[1] + r_cnt[0]))
            2'd0:    w_part = 128'(w_prod);
            2'd1:    w_part = 128'(w_prod) << 32;
            default: w_part = 128'(w_prod) << 64;
        endcase

        w_rem2 = {r_rem, r_acc[127]};
        w_ge   = (w_rem2 >= {1'b0, r_den});

        case (w_uop.op)
            OP_MUL:  w_fmag = r_acc >> FRAC_BITS;
            OP_DIV6: w_fmag = r_acc >> 65;
            default: w_fmag = r_acc;
        endcase
        w_val  = (r_state == ST_FIN) ? from_mag(r_neg, w_fmag) : w_alu;
        w_wen  = ((r_state == ST_ISSUE) && w_simple && (w_uop.op != OP_NOP))
                 || (r_state == ST_FIN);
        w_adv  = ((r_state == ST_ISSUE) && w_simple) || (r_state == ST_FIN);
        w_last = (r_idx == ((r_stage == 2'd3) ? LAST_FIN : LAST_MID));

        w_dt   = i_in_data.sim_time - r_prev;
        w_hsum = w_dt + 64'(w_dt[63]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res   <= ONE_CFG;
            r_ind   <= ONE_CFG;
            r_lam   <= ONE_CFG;
            r_poles <= 7'd1;
            r_tsf   <= '0;
            r_mu    <= '0;
            r_tl    <= '0;
            r_jl    <= ONE_CFG;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_RES:   r_res   <= i_cfg_data[46:0];
                CFG_IND:   r_ind   <= i_cfg_data[46:0];
                CFG_LAM:   r_lam   <= i_cfg_data[46:0];
                CFG_POLES: r_poles <= i_cfg_data[6:0];
                CFG_TSF:   r_tsf   <= i_cfg_data;
                CFG_MU:    r_mu    <= i_cfg_data[46:0];
                CFG_TL:    r_tl    <= i_cfg_data;
                CFG_JL:    r_jl    <= i_cfg_data[46:0];
                default:   r_res   <= r_res;
            endcase
        end
    end

    // State, previous time and the integrated state values reset to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            for (int n = 0; n < 4; n++) begin
                r_x[n] <= '0;
            end
        end else begin
            if (w_fire) begin
                r_prev <= i_in_data.sim_time;
            end
            if (w_wen) begin
                case (w_uop.dst)
                    R_X0: r_x[0] <= w_val;
                    R_X1: r_x[1] <= w_val;
                    R_X2: r_x[2] <= w_val;
                    R_X3: r_x[3] <= w_val;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_dt <= w_dt;
            r_h  <= {w_hsum[63], w_hsum[63:1]};
            r_vd <= {{16{i_in_data.volt_d[47]}}, i_in_data.volt_d};
            r_vq <= {{16{i_in_data.volt_q[47]}}, i_in_data.volt_q};
            for (int n = 0; n < 4; n++) begin
                r_s[n] <= r_x[n];
            end
        end
        if (w_wen) begin
            case (w_uop.dst)
                R_S0: r_s[0]  <= w_val;
                R_S1: r_s[1]  <= w_val;
                R_S2: r_s[2]  <= w_val;
                R_S3: r_s[3]  <= w_val;
                R_K0: r_k[0]  <= w_val;
                R_K1: r_k[1]  <= w_val;
                R_K2: r_k[2]  <= w_val;
                R_K3: r_k[3]  <= w_val;
                R_A0: r_ka[0] <= w_val;
                R_A1: r_ka[1] <= w_val;
                R_A2: r_ka[2] <= w_val;
                R_A3: r_ka[3] <= w_val;
                R_B0: r_kb[0] <= w_val;
                R_B1: r_kb[1] <= w_val;
                R_B2: r_kb[2] <= w_val;
                R_B3: r_kb[3] <= w_val;
                R_C0: r_kc[0] <= w_val;
                R_C1: r_kc[1] <= w_val;
                R_C2: r_kc[2] <= w_val;
                R_C3: r_kc[3] <= w_val;
                R_T0: r_t0    <= w_val;
                R_T1: r_t1    <= w_val;
                R_T2: r_t2    <= w_val;
                default: ;
            endcase
        end

        // Multiplier operands and the dividend enter as magnitudes; the divisor enters as it
        // is, zero replaced by one. The sign is applied when the result is written back.
        if ((r_state == ST_ISSUE) && (w_uop.op == OP_MUL)) begin
            r_ma  <= mag(w_opa);
            r_mb  <= mag(w_opb);
            r_neg <= w_opa[63] ^ w_opb[63];
            r_acc <= '0;
        end else if ((r_state == ST_ISSUE) && (w_uop.op == OP_DIV6)) begin
            r_ma  <= mag(w_opa) >> 1;
            r_mb  <= RECIP3;
            r_neg <= w_opa[63];
            r_acc <= '0;
        end else if ((r_state == ST_ISSUE) && (w_uop.op == OP_DIV)) begin
            r_acc <= 128'(mag(w_opa)) << FRAC_BITS;
            r_rem <= '0;
            r_den <= (w_opb == 64'd0) ? 64'd1 : w_opb;
            r_neg <= w_opa[63];
        end else if (r_state == ST_MUL) begin
            r_acc <= r_acc + w_part;
        end else if (r_state == ST_DIV) begin
            r_acc <= {r_acc[126:0], w_ge};
            r_rem <= w_ge ? 64'(w_rem2 - {1'b0, r_den}) : w_rem2[63:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_stage     <= '0;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_fire) begin
                        r_stage <= '0;
                        r_idx   <= '0;
                        r_state <= (i_in_data.sim_time == 64'd0) ? ST_DONE : ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    r_cnt <= '0;
                    if ((w_uop.op == OP_MUL) || (w_uop.op == OP_DIV6)) begin
                        r_state <= ST_MUL;
                    end else if (w_uop.op == OP_DIV) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_MUL: begin
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt[1:0] == 2'd3) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd127) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    r_state <= ST_ISSUE;
                end
                ST_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out.current_d   <= r_x[0][STATE_WIDTH-1:0];
                        r_out.current_q   <= r_x[1][STATE_WIDTH-1:0];
                        r_out.rotor_angle <= r_x[2][STATE_WIDTH-1:0];
                        r_out.rotor_speed <= r_x[3][STATE_WIDTH-1:0];
                        r_out_valid       <= 1'b1;
                        r_state           <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (w_adv) begin
                if (w_last) begin
                    r_idx <= '0;
                    if (r_stage == 2'd3) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_stage <= r_stage + 2'd1;
                        r_state <= ST_ISSUE;
                    end
                end else begin
                    r_idx   <= r_idx + 6'd1;
                    r_state <= ST_ISSUE;
                end
            end
        end
    end

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_den != 64'd0))
        else $error("divider running with a zero divisor");

    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_den))
        else $error("division remainder not below divisor");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= ((r_stage == 2'd3) ? LAST_FIN : LAST_MID))
        else $error("microprogram step beyond end of stage");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result presented outside completion");

endmodule

// ===== bench/pmsm_dq_rk4_step_top_tb.sv =====
module pmsm_dq_rk4_step_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pmsm_pkg::*;

    typedef longint t_vec4 [4];

    localparam longint FX_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam longint FX_MIN = 64'sh8000_0000_0000_0000;
    localparam longint ST_MAX = 64'sh0000_7fff_ffff_ffff;
    localparam longint ST_MIN = -64'sh0000_8000_0000_0000;
    localparam longint ONE_FX = 64'sh1_0000_0000;

    class dq_scoreboard;
        longint    res, ind, lam, poles, tsf, mu, tl, jl;
        logic [63:0] prev_time;
        longint    st [4];
        t_out_item state_q [$];
        int        mismatches;

        function new();
            res = ONE_FX; ind = ONE_FX; lam = ONE_FX; poles = 1;
            tsf = 0; mu = 0; tl = 0; jl = ONE_FX;
            prev_time = '0;
            foreach (st[i]) st[i] = 0;
            mismatches = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [47:0] v);
            case (idx)
                CFG_RES:   res = longint'(v[46:0]);
                CFG_IND:   ind = longint'(v[46:0]);
                CFG_LAM:   lam = longint'(v[46:0]);
                CFG_POLES: poles = longint'(v[6:0]);
                CFG_TSF:   tsf = longint'($signed(v));
                CFG_MU:    mu = longint'(v[46:0]);
                CFG_TL:    tl = longint'($signed(v));
                default:   jl = longint'(v[46:0]);
            endcase
        endfunction

        function longint sat_add(longint a, longint b);
            longint s;
            s = a + b;
            if (a[63] == b[63] && s[63] != a[63]) return a[63] ? FX_MIN : FX_MAX;
            return s;
        endfunction

        function longint sat_sub(longint a, longint b);
            longint s;
            s = a - b;
            if (a[63] != b[63] && s[63] != a[63]) return a[63] ? FX_MIN : FX_MAX;
            return s;
        endfunction

        function longint from_mag(bit neg, logic [127:0] m);
            if (neg) begin
                if (m > 128'h8000_0000_0000_0000) return FX_MIN;
                return -longint'(m[63:0]);
            end
            if (m > 128'h7fff_ffff_ffff_ffff) return FX_MAX;
            return longint'(m[63:0]);
        endfunction

        function longint fx_mul(longint a, longint b);
            logic [63:0]  ua, ub;
            logic [127:0] p;
            ua = a[63] ? -a : a;
            ub = b[63] ? -b : b;
            p = {64'd0, ua} * {64'd0, ub};
            p = p >> FRAC_BITS;
            return from_mag(a[63] ^ b[63], p);
        endfunction

        function longint fx_div(longint a, longint d);
            logic [63:0]  ua, ud;
            logic [127:0] q;
            ua = a[63] ? -a : a;
            ud = (d == 0) ? 64'd1 : d;
            q = ({64'd0, ua} << FRAC_BITS) / {64'd0, ud};
            return from_mag(a[63], q);
        endfunction

        function longint sat_state(longint v);
            if (v > ST_MAX) return ST_MAX;
            if (v < ST_MIN) return ST_MIN;
            return v;
        endfunction

        // Slopes of id, iq, angle and speed at state x.
        function t_vec4 slopes(t_vec4 x, longint vd, longint vq);
            t_vec4  k;
            longint np, te, t;
            np = poles <<< FRAC_BITS;
            te = fx_mul(fx_mul(fx_mul(3 * (ONE_FX / 2), np), lam), x[1]);
            k[0] = sat_add(fx_div(sat_sub(vd, fx_mul(res, x[0])), ind),
                           fx_mul(fx_mul(np, x[3]), x[1]));
            t = fx_mul(fx_mul(sat_add(fx_div(lam, ind), x[0]), np), x[3]);
            k[1] = sat_sub(fx_div(sat_sub(vq, fx_mul(res, x[1])), ind), t);
            k[2] = x[3];
            t = sat_sub(sat_sub(sat_sub(te, tsf), fx_mul(mu, x[3])), tl);
            k[3] = fx_div(t, jl);
            return k;
        endfunction

        function void note_input(t_in_item it);
            longint    vd, vq, dt, h, s, dlt;
            t_vec4     x, xs, k1, k2, k3, k4;
            t_out_item e;
            vd = it.volt_d;
            vq = it.volt_q;
            dt = it.sim_time - prev_time;
            prev_time = it.sim_time;
            if (it.sim_time != 0) begin
                h = dt / 2;
                x = st;
                k1 = slopes(x, vd, vq);
                foreach (xs[i]) xs[i] = sat_add(x[i], fx_mul(k1[i], h));
                k2 = slopes(xs, vd, vq);
                foreach (xs[i]) xs[i] = sat_add(x[i], fx_mul(k2[i], h));
                k3 = slopes(xs, vd, vq);
                foreach (xs[i]) xs[i] = sat_add(x[i], fx_mul(k3[i], dt));
                k4 = slopes(xs, vd, vq);
                for (int i = 0; i < 4; i++) begin
                    s = sat_add(k1[i], k4[i]);
                    s = sat_add(s, sat_add(k2[i], k2[i]));
                    s = sat_add(s, sat_add(k3[i], k3[i]));
                    dlt = fx_mul(s, dt) / 6;
                    // The angle wraps; the other state values saturate.
                    if (i == 2) st[i] = longint'($signed(48'(st[i] + dlt)));
                    else        st[i] = sat_state(sat_add(st[i], dlt));
                end
            end
            e.current_d   = st[0][47:0];
            e.current_q   = st[1][47:0];
            e.rotor_angle = st[2][47:0];
            e.rotor_speed = st[3][47:0];
            state_q.push_back(e);
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            if (state_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected output transfer %h", got);
                return;
            end
            e = state_q.pop_front();
            if (got.current_d !== e.current_d || got.current_q !== e.current_q ||
                got.rotor_angle !== e.rotor_angle || got.rotor_speed !== e.rotor_speed) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("State mismatch: id %h/%h iq %h/%h angle %h/%h speed %h/%h (exp/got)",
                             e.current_d, got.current_d, e.current_q, got.current_q,
                             e.rotor_angle, got.rotor_angle, e.rotor_speed, got.rotor_speed);
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_in_item             i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    dq_scoreboard sb = new();
    bit           idling_on = 1'b1;
    bit           hold_out = 1'b0;
    logic [63:0]  cur_time = '0;

    pmsm_dq_rk4_step_top u_dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) sb.note_input(i_in_data);
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_data);
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        @(posedge i_clk);
        forever begin
            if (hold_out) begin
                i_out_ready <= 1'b0;
                repeat (10000) @(posedge i_clk);
                hold_out = 1'b0;
            end else if (idling_on && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_item(logic [63:0] t, logic [47:0] vd, logic [47:0] vq);
        t_in_item it;
        it.sim_time = t;
        it.volt_d = vd;
        it.volt_q = vq;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.state_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [47:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, v);
    endtask

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    function automatic logic [47:0] rand_volt();
        longint v;
        v = longint'($signed($urandom)) <<< 4;
        return v[47:0];
    endfunction

    task automatic random_items(int n);
        int kind;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                cur_time += 64'($urandom_range(1, 1 << 22));
                send_item(cur_time, rand_volt(), rand_volt());
            end else if (kind < 78) begin
                send_item(64'd0, rand_volt(), rand_volt());
            end else if (kind < 86) begin
                cur_time -= 64'($urandom_range(1, 1 << 22));
                send_item(cur_time, rand_volt(), rand_volt());
            end else if (kind < 93) begin
                cur_time += 64'($urandom_range(1, 1 << 22));
                send_item(cur_time, rand48(), rand48());
            end else begin
                cur_time = {$urandom, $urandom};
                send_item(cur_time, rand_volt(), rand48());
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: zero time, forward, backward and extreme times and voltages.
        send_item(64'd0, 48'h1_0000_0000, 48'h2_0000_0000);
        send_item(64'h1_0000_0000, 48'h1_0000_0000, 48'h2_0000_0000);
        send_item(64'h1_0010_0000, 48'h7fff_ffff_ffff, 48'h8000_0000_0000);
        send_item(64'h1_0008_0000, 48'h8000_0000_0000, 48'h7fff_ffff_ffff);
        send_item(64'hffff_ffff_ffff_ffff, 48'h0, 48'hffff_ffff_ffff);
        send_item(64'd0, 48'h0, 48'h0);
        send_item(64'h0000_0000_0000_1000, 48'hffff_0000_0000, 48'h0001_0000_0000);
        drain();

        // Extremes, with zero divisors and zero pole pairs.
        write_cfg(CFG_RES, '1);
        write_cfg(CFG_IND, '0);
        write_cfg(CFG_LAM, '1);
        write_cfg(CFG_POLES, '0);
        write_cfg(CFG_TSF, 48'h8000_0000_0000);
        write_cfg(CFG_MU, '1);
        write_cfg(CFG_TL, 48'h7fff_ffff_ffff);
        write_cfg(CFG_JL, '0);
        cur_time = 64'h10_0000_0000;
        send_item(cur_time, 48'h7fff_ffff_ffff, 48'h8000_0000_0000);
        send_item(cur_time + 64'h100, 48'h1_0000_0000, 48'h0);
        send_item(cur_time + 64'h80, 48'h0, 48'hffff_ffff_ffff);
        send_item(64'd0, 48'h0, 48'h0);
        drain();

        write_cfg(CFG_RES, '0);
        write_cfg(CFG_IND, 48'h7fff_ffff_ffff);
        write_cfg(CFG_LAM, '0);
        write_cfg(CFG_POLES, 48'd64);
        write_cfg(CFG_TSF, 48'h7fff_ffff_ffff);
        write_cfg(CFG_MU, '0);
        write_cfg(CFG_TL, 48'h8000_0000_0000);
        write_cfg(CFG_JL, 48'h7fff_ffff_ffff);
        send_item(64'h20_0000_0000, 48'h7fff_ffff_ffff, 48'h7fff_ffff_ffff);
        send_item(64'h20_4000_0000, 48'h8000_0000_0000, 48'h8000_0000_0000);
        send_item(64'h8000_0000_0000_0000, 48'h1_0000_0000, 48'h1_0000_0000);
        drain();

        cur_time = 64'h1_0000_0000;
        for (int ph = 0; ph < 6; ph++) begin
            write_cfg(CFG_RES, 48'($urandom_range(0, 32'hffff_ffff)));
            write_cfg(CFG_IND, 48'($urandom_range(1 << 22, 32'hffff_ffff)));
            write_cfg(CFG_LAM, 48'($urandom_range(0, 32'hffff_ffff)));
            write_cfg(CFG_POLES, 48'($urandom_range(1, 8)));
            write_cfg(CFG_TSF, 48'(longint'($signed($urandom)) >>> 2));
            write_cfg(CFG_MU, 48'($urandom_range(0, 1 << 28)));
            write_cfg(CFG_TL, 48'(longint'($signed($urandom)) >>> 2));
            write_cfg(CFG_JL, 48'($urandom_range(1 << 24, 32'h7fff_ffff)));
            if (ph == 5) idling_on = 1'b0;
            // The block fills up and stalls its input behind a long output hold-off.
            if (ph == 1) hold_out = 1'b1;
            random_items(250);
            drain();
        end

        if (sb.mismatches == 0 && sb.state_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #300_000_000;
        $display("Mismatches found");
        $finish;
    end
endmodule

// ===== sim.f =====
src/pmsm_pkg.sv
src/pmsm_dq_rk4_step_top.sv
bench/pmsm_dq_rk4_step_top_tb.sv
